// ----- rtl/core/pibs_pkg.sv -----
package pibs_pkg;

  localparam int ALLELE_W = 16;
  localparam int SHARED_W = 18;
  localparam int COUNT_W  = 17;
  localparam int SCORE_W  = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_CODING_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_CLASSES = 1'd1;

  localparam logic [SCORE_W-1:0] SCORE_NONE = 2'd0;
  localparam logic [SCORE_W-1:0] SCORE_HALF = 2'd1;
  localparam logic [SCORE_W-1:0] SCORE_FULL = 2'd2;

  typedef struct packed {
    logic signed [ALLELE_W-1:0] allele_a1;
    logic signed [ALLELE_W-1:0] allele_a2;
    logic signed [ALLELE_W-1:0] allele_b1;
    logic signed [ALLELE_W-1:0] allele_b2;
    logic                       same_individual;
    logic                       last_locus;
  } in_item_t;

  typedef struct packed {
    logic [SHARED_W-1:0] shared_halves;
    logic [COUNT_W-1:0]  missing_loci;
    logic [COUNT_W-1:0]  ibs_zero_count;
    logic [COUNT_W-1:0]  ibs_one_count;
    logic [COUNT_W-1:0]  ibs_two_count;
  } out_item_t;

  // per-locus increments for the accumulators
  typedef struct packed {
    logic               add_missing;
    logic [SCORE_W-1:0] add_shared;
    logic               add_zero;
    logic               add_half;
    logic               add_full;
  } locus_eval_t;

endpackage

// ----- rtl/core/pibs_score.sv -----
module pibs_score import pibs_pkg::*; (
  input  logic        coding_mode,
  input  logic        count_ibs_classes,
  input  in_item_t    item,
  output locus_eval_t eval
);

  logic                 neg_a1, neg_a2, neg_b1, neg_b2;
  logic                 missing;
  logic signed [ALLELE_W:0] diff;
  logic                 eq11, eq22, eq12, eq21;
  logic [SCORE_W-1:0]   score_cnt, score_pair, score;

  always_comb begin
    neg_a1 = item.allele_a1[ALLELE_W-1];
    neg_a2 = item.allele_a2[ALLELE_W-1];
    neg_b1 = item.allele_b1[ALLELE_W-1];
    neg_b2 = item.allele_b2[ALLELE_W-1];

    if (item.same_individual) begin
      missing = coding_mode ? (neg_a1 | neg_a2) : neg_a1;
    end else begin
      missing = coding_mode ? (neg_a1 | neg_a2 | neg_b1 | neg_b2) : (neg_a1 | neg_b1);
    end

    // count coding
    diff = {item.allele_a1[ALLELE_W-1], item.allele_a1}
         - {item.allele_b1[ALLELE_W-1], item.allele_b1};
    if (diff == '0) begin
      score_cnt = SCORE_FULL;
    end else if (diff == (ALLELE_W+1)'(1) || diff == '1) begin
      score_cnt = SCORE_HALF;
    end else begin
      score_cnt = SCORE_NONE;
    end

    // two-allele coding, either order
    eq11 = item.allele_a1 == item.allele_b1;
    eq22 = item.allele_a2 == item.allele_b2;
    eq12 = item.allele_a1 == item.allele_b2;
    eq21 = item.allele_a2 == item.allele_b1;
    if (eq11) begin
      score_pair = eq22 ? SCORE_FULL : SCORE_HALF;
    end else if (eq12) begin
      score_pair = eq21 ? SCORE_FULL : SCORE_HALF;
    end else if (eq22 || eq21) begin
      score_pair = SCORE_HALF;
    end else begin
      score_pair = SCORE_NONE;
    end

    score = coding_mode ? score_pair : score_cnt;

    eval = '0;
    eval.add_missing = missing;
    if (!item.same_individual && !missing) begin
      eval.add_shared = score;
      eval.add_full   = count_ibs_classes && (score == SCORE_FULL);
      eval.add_half   = count_ibs_classes && (score == SCORE_HALF);
      eval.add_zero   = count_ibs_classes && (score == SCORE_NONE);
    end
  end

endmodule

// ----- rtl/core/pibs_accum.sv -----
module pibs_accum import pibs_pkg::*; #(
  parameter int MAX_LOCI = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        last,
  input  locus_eval_t eval,
  output out_item_t   totals
);

  localparam longint unsigned SHARED_MAX = (64'd1 << SHARED_W) - 64'd1;
  localparam longint unsigned COUNT_MAX  = (64'd1 << COUNT_W) - 64'd1;
  localparam longint unsigned SHARED_CAP_L =
    (2 * longint'(MAX_LOCI) > SHARED_MAX) ? SHARED_MAX : 2 * longint'(MAX_LOCI);
  localparam longint unsigned COUNT_CAP_L =
    (longint'(MAX_LOCI) > COUNT_MAX) ? COUNT_MAX : longint'(MAX_LOCI);
  localparam logic [SHARED_W-1:0] SHARED_CAP = SHARED_CAP_L[SHARED_W-1:0];
  localparam logic [COUNT_W-1:0]  COUNT_CAP  = COUNT_CAP_L[COUNT_W-1:0];

  logic [SHARED_W-1:0] shared_sum, shared_sum_next;
  logic [COUNT_W-1:0]  missing_sum, missing_sum_next;
  logic [COUNT_W-1:0]  zero_class_sum, zero_class_sum_next;
  logic [COUNT_W-1:0]  half_class_sum, half_class_sum_next;
  logic [COUNT_W-1:0]  full_class_sum, full_class_sum_next;

  function automatic logic [COUNT_W-1:0] count_add(input logic [COUNT_W-1:0] acc,
                                                   input logic inc);
    logic [COUNT_W:0] s;
    s = {1'b0, acc} + {{COUNT_W{1'b0}}, inc};
    return (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[COUNT_W-1:0];
  endfunction

  logic [SHARED_W:0] shared_wide;

  always_comb begin
    shared_wide = {1'b0, shared_sum} + {{(SHARED_W-1){1'b0}}, eval.add_shared};
    shared_sum_next = (shared_wide > {1'b0, SHARED_CAP}) ? SHARED_CAP
                                                         : shared_wide[SHARED_W-1:0];
    missing_sum_next    = count_add(missing_sum, eval.add_missing);
    zero_class_sum_next = count_add(zero_class_sum, eval.add_zero);
    half_class_sum_next = count_add(half_class_sum, eval.add_half);
    full_class_sum_next = count_add(full_class_sum, eval.add_full);

    totals.shared_halves  = shared_sum_next;
    totals.missing_loci   = missing_sum_next;
    totals.ibs_zero_count = zero_class_sum_next;
    totals.ibs_one_count  = half_class_sum_next;
    totals.ibs_two_count  = full_class_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      shared_sum     <= '0;
      missing_sum    <= '0;
      zero_class_sum <= '0;
      half_class_sum <= '0;
      full_class_sum <= '0;
    end else if (step) begin
      shared_sum     <= shared_sum_next;
      missing_sum    <= missing_sum_next;
      zero_class_sum <= zero_class_sum_next;
      half_class_sum <= half_class_sum_next;
      full_class_sum <= full_class_sum_next;
    end
  end

endmodule

// ----- rtl/core/pairwise_ibs_sharing_accumulator.sv -----
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | in_item (in_item_t)
// out     | output    | out_valid / out_ready | out_item (out_item_t)
// cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// one locus per cycle; an item is held in the input register, is scored
// and added there, and a last locus loads the result register at the same edge.
// a result passes from the input register to the result register, which sets out_valid.
// synchronous reset clears sums, valids and config (coding 0, class counting on).
// only a last locus waits on a full result register; other loci stall only behind it.
module pairwise_ibs_sharing_accumulator import pibs_pkg::*; #(
  parameter int MAX_LOCI = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  logic        coding_mode;
  logic        count_ibs_classes;
  logic        stage_valid;
  in_item_t    stage_item;
  logic        step;
  locus_eval_t eval;
  out_item_t   totals;

  assign step     = stage_valid && (!stage_item.last_locus || !out_valid || out_ready);
  assign in_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode       <= 1'b0;
      count_ibs_classes <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CODING_MODE:   coding_mode       <= cfg_data[0];
        REG_COUNT_CLASSES: count_ibs_classes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  pibs_score u_score (
    .coding_mode       (coding_mode),
    .count_ibs_classes (count_ibs_classes),
    .item              (stage_item),
    .eval              (eval)
  );

  pibs_accum #(
    .MAX_LOCI (MAX_LOCI)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .last   (stage_item.last_locus),
    .eval   (eval),
    .totals (totals)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && stage_item.last_locus) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step && stage_item.last_locus) begin
      out_item.shared_halves  <= totals.shared_halves;
      out_item.missing_loci   <= totals.missing_loci;
      out_item.ibs_zero_count <= count_ibs_classes ? totals.ibs_zero_count : '0;
      out_item.ibs_one_count  <= count_ibs_classes ? totals.ibs_one_count : '0;
      out_item.ibs_two_count  <= count_ibs_classes ? totals.ibs_two_count : '0;
    end
  end

endmodule

// ----- bench/pibs_tally_pkg.sv -----
package pibs_tally_pkg;
  import pibs_pkg::*;

  localparam int MAX_LOCI = 65536;
  localparam int SHARED_TOP = (1 << SHARED_W) - 1;
  localparam int COUNT_TOP = (1 << COUNT_W) - 1;
  localparam int SHARED_CAP = (2 * MAX_LOCI > SHARED_TOP) ? SHARED_TOP : 2 * MAX_LOCI;
  localparam int COUNT_CAP = (MAX_LOCI > COUNT_TOP) ? COUNT_TOP : MAX_LOCI;

  class ibs_tally;
    logic coding_pairs;
    logic classes_on;
    int shared_sum;
    int missing_sum;
    int zero_sum;
    int half_sum;
    int full_sum;
    out_item_t pair_totals_q[$];
    int errors;

    function new();
      coding_pairs = 1'b0;
      classes_on = 1'b1;
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      shared_sum = 0;
      missing_sum = 0;
      zero_sum = 0;
      half_sum = 0;
      full_sum = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic val);
      if (idx == REG_CODING_MODE) coding_pairs = val;
      else if (idx == REG_COUNT_CLASSES) classes_on = val;
    endfunction

    function int bump(int acc, int add, int cap);
      return (acc + add > cap) ? cap : acc + add;
    endfunction

    function logic [SCORE_W-1:0] count_score(int a, int b);
      if (a == b) return SCORE_FULL;
      if (a - b == 1 || b - a == 1) return SCORE_HALF;
      return SCORE_NONE;
    endfunction

    function logic [SCORE_W-1:0] pair_score(int a1, int a2, int b1, int b2);
      if (a1 == b1) return (a2 == b2) ? SCORE_FULL : SCORE_HALF;
      if (a1 == b2) return (a2 == b1) ? SCORE_FULL : SCORE_HALF;
      if (a2 == b2 || a2 == b1) return SCORE_HALF;
      return SCORE_NONE;
    endfunction

    function int pending();
      return pair_totals_q.size();
    endfunction

    // accepted locus: update running sums, queue the totals on a last locus
    function void note_locus(in_item_t it);
      int a1;
      int a2;
      int b1;
      int b2;
      logic gone;
      logic [SCORE_W-1:0] sc;
      out_item_t res;
      a1 = int'($signed(it.allele_a1));
      a2 = int'($signed(it.allele_a2));
      b1 = int'($signed(it.allele_b1));
      b2 = int'($signed(it.allele_b2));
      if (it.same_individual) begin
        gone = coding_pairs ? (a1 < 0 || a2 < 0) : (a1 < 0);
        if (gone) missing_sum = bump(missing_sum, 1, COUNT_CAP);
      end else begin
        gone = coding_pairs ? (a1 < 0 || a2 < 0 || b1 < 0 || b2 < 0) : (a1 < 0 || b1 < 0);
        if (gone) begin
          missing_sum = bump(missing_sum, 1, COUNT_CAP);
        end else begin
          sc = coding_pairs ? pair_score(a1, a2, b1, b2) : count_score(a1, b1);
          shared_sum = bump(shared_sum, int'(sc), SHARED_CAP);
          if (classes_on) begin
            if (sc == SCORE_FULL) full_sum = bump(full_sum, 1, COUNT_CAP);
            else if (sc == SCORE_HALF) half_sum = bump(half_sum, 1, COUNT_CAP);
            else zero_sum = bump(zero_sum, 1, COUNT_CAP);
          end
        end
      end
      if (it.last_locus) begin
        res.shared_halves = SHARED_W'(shared_sum);
        res.missing_loci = COUNT_W'(missing_sum);
        res.ibs_zero_count = classes_on ? COUNT_W'(zero_sum) : '0;
        res.ibs_one_count = classes_on ? COUNT_W'(half_sum) : '0;
        res.ibs_two_count = classes_on ? COUNT_W'(full_sum) : '0;
        pair_totals_q.push_back(res);
        clear_sums();
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pair_totals_q.size() == 0) begin
        $error("result item with no pair pending");
        errors++;
        return;
      end
      want = pair_totals_q.pop_front();
      compare_field("shared_halves", want.shared_halves, got.shared_halves);
      compare_field("missing_loci", want.missing_loci, got.missing_loci);
      compare_field("ibs_zero_count", want.ibs_zero_count, got.ibs_zero_count);
      compare_field("ibs_one_count", want.ibs_one_count, got.ibs_one_count);
      compare_field("ibs_two_count", want.ibs_two_count, got.ibs_two_count);
    endfunction
  endclass

endpackage

// ----- bench/pairwise_ibs_sharing_accumulator_test.sv -----
module pairwise_ibs_sharing_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pibs_pkg::*;
  import pibs_tally_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_CODING_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  ibs_tally tally;
  int idle_cycles = 0;

  pairwise_ibs_sharing_accumulator #(.MAX_LOCI(MAX_LOCI)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic int draw_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 19);
  endfunction

  function automatic in_item_t locus(int a1, int a2, int b1, int b2, bit diag, bit last);
    in_item_t it;
    it.allele_a1 = 16'(a1);
    it.allele_a2 = 16'(a2);
    it.allele_b1 = 16'(b1);
    it.allele_b2 = 16'(b2);
    it.same_individual = diag;
    it.last_locus = last;
    return it;
  endfunction

  // mostly small alleles so that matches are common, plus missing and wide values
  function automatic logic [ALLELE_W-1:0] pick_allele();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ALLELE_W'($urandom) | 16'h8000;
    if (r < 20) return ALLELE_W'($urandom);
    if (r < 24) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    return ALLELE_W'($urandom_range(0, 3));
  endfunction

  function automatic in_item_t random_locus(bit diag, bit last);
    return locus(int'($signed(pick_allele())), int'($signed(pick_allele())),
                 int'($signed(pick_allele())), int'($signed(pick_allele())), diag, last);
  endfunction

  task automatic send_locus(input in_item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally.note_locus(it);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tally.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tally.set_reg(idx, val);
  endtask

  task automatic set_modes(input logic pairs, input logic classes);
    write_reg(REG_CODING_MODE, pairs);
    write_reg(REG_COUNT_CLASSES, classes);
    cfg_write <= 1'b0;
  endtask

  initial begin : stall_watch
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_sink
    int gap;
    bit steady;
    steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = draw_gap(steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tally.check_result(out_item);
    end
  end

  initial begin : stimulus
    int sent;
    int pairs;
    int len;
    bit diag;
    bit steady;
    tally = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count coding
    set_modes(1'b0, 1'b1);
    send_locus(locus(0, 0, 0, 0, 0, 0), draw_gap(0));
    send_locus(locus(5, 0, 6, 0, 0, 0), draw_gap(0));
    send_locus(locus(6, 0, 5, 0, 0, 0), draw_gap(0));
    send_locus(locus(32767, 0, 0, 0, 0, 0), draw_gap(0));
    send_locus(locus(-1, 0, 3, 0, 0, 0), draw_gap(0));
    send_locus(locus(2, 0, -32768, 0, 0, 0), draw_gap(0));
    send_locus(locus(-5, 7, 7, 7, 1, 0), draw_gap(0));
    send_locus(locus(32767, 0, -1, 0, 1, 0), draw_gap(0));
    send_locus(locus(3, -1, 3, -32768, 0, 1), draw_gap(0));
    send_locus(locus(32767, 0, 32766, 0, 0, 1), draw_gap(0));

    // two-allele coding
    drain();
    set_modes(1'b1, 1'b1);
    send_locus(locus(1, 2, 1, 2, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 2, 1, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 1, 3, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 3, 1, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 2, 3, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 3, 2, 0, 0), draw_gap(0));
    send_locus(locus(1, 2, 3, 4, 0, 0), draw_gap(0));
    send_locus(locus(1, 1, 1, 2, 0, 0), draw_gap(0));
    send_locus(locus(1, -1, 1, 1, 0, 0), draw_gap(0));
    send_locus(locus(1, 1, 1, -32768, 0, 0), draw_gap(0));
    send_locus(locus(4, -1, 4, 4, 1, 0), draw_gap(0));
    send_locus(locus(4, 4, -1, -1, 1, 0), draw_gap(0));
    send_locus(locus(32767, 32767, 32767, 0, 0, 1), draw_gap(0));

    // class counting switched off in the middle of a pair
    send_locus(locus(4, 4, 4, 4, 0, 0), draw_gap(0));
    drain();
    write_reg(REG_COUNT_CLASSES, 1'b0);
    cfg_write <= 1'b0;
    send_locus(locus(4, 5, 4, 5, 0, 1), draw_gap(0));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      pairs = $urandom_range(1, 8);
      repeat (pairs) begin
        if ($urandom_range(0, 19) == 0) wait_results();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        diag = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          send_locus(random_locus(diag, k == len - 1), draw_gap(steady));
          sent++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tally.errors == 0 && tally.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pibs_pkg.sv
rtl/core/pibs_score.sv
rtl/core/pibs_accum.sv
rtl/core/pairwise_ibs_sharing_accumulator.sv
bench/pibs_tally_pkg.sv
bench/pairwise_ibs_sharing_accumulator_test.sv
